// File: rtl/nmp_pkg.sv
// Package with the types, codes and constants shared by the TLV message parser files.
package nmp_pkg;

	// Parse phase; the numeric value doubles as the byte role of the byte.
	typedef enum logic [2:0] {
		PH_TYPE = 3'd0,
		PH_NLEN = 3'd1,
		PH_NAME = 3'd2,
		PH_VHI  = 3'd3,
		PH_VLO  = 3'd4,
		PH_VAL  = 3'd5
	} phase_t;

	// Role reported for bytes that follow a protocol error.
	localparam logic [2:0] ROLE_DISCARD = 3'd6;

	// Element type codes as they appear in the type byte.
	localparam logic [7:0] TYPE_SECTION_START = 8'd1;
	localparam logic [7:0] TYPE_SECTION_END   = 8'd2;
	localparam logic [7:0] TYPE_KEY_VALUE     = 8'd3;
	localparam logic [7:0] TYPE_LIST_START    = 8'd4;
	localparam logic [7:0] TYPE_LIST_ITEM     = 8'd5;
	localparam logic [7:0] TYPE_LIST_END      = 8'd6;

	// Element kind codes as reported on the result.
	localparam logic [2:0] KIND_NONE          = 3'd0;
	localparam logic [2:0] KIND_SECTION_START = 3'd1;
	localparam logic [2:0] KIND_SECTION_END   = 3'd2;
	localparam logic [2:0] KIND_KEY_VALUE     = 3'd3;
	localparam logic [2:0] KIND_LIST_START    = 3'd4;
	localparam logic [2:0] KIND_LIST_ITEM     = 3'd5;
	localparam logic [2:0] KIND_LIST_END      = 3'd6;

	// Hard ceiling on section nesting, applied on top of the register.
	localparam logic [7:0] DEPTH_LIMIT = 8'd15;

	// Reset value of the depth register.
	localparam logic [3:0] MAX_DEPTH_RESET = 4'd8;

	// Parser state carried from one byte to the next.
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  section_depth;
		logic        list_open;
		logic [15:0] bytes_left;
		logic [7:0]  length_high;
		logic [2:0]  current_kind;
		logic        error_seen;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:         PH_TYPE,
		section_depth: 4'd0,
		list_open:     1'b0,
		bytes_left:    16'd0,
		length_high:   8'd0,
		current_kind:  KIND_NONE,
		error_seen:    1'b0
	};

	// Tagged result for one byte.
	typedef struct packed {
		logic [7:0] byte_out;
		logic [2:0] byte_role;
		logic [2:0] element_kind;
		logic [3:0] nest_depth;
		logic       element_done;
		logic       message_done;
		logic       protocol_error;
	} parse_result_t;

endpackage

// File: rtl/nmp_step.sv
// Combinational parse step: next parser state and tagged result for one byte.
module nmp_step import nmp_pkg::*; #(
	parameter logic [7:0] NEST_LIMIT = DEPTH_LIMIT
) (
	input  parse_state_t  cur,
	input  logic [3:0]    max_depth,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic [2:0]  role;
	logic [2:0]  kind;
	logic [3:0]  depth;
	logic        done;
	logic        err;
	logic [3:0]  depth_inc;
	logic [15:0] count_dec;
	logic [15:0] value_len;

	assign depth_inc = cur.section_depth + 4'd1;
	assign count_dec = cur.bytes_left - 16'd1;
	assign value_len = {cur.length_high, data_byte};

	// Phase decode, element checks and state update.
	always_comb begin
		nxt   = cur;
		role  = ROLE_DISCARD;
		kind  = KIND_NONE;
		depth = 4'd0;
		done  = 1'b0;
		err   = 1'b0;
		if (!cur.error_seen) begin
			role  = 3'(cur.phase);
			depth = cur.section_depth;
			case (cur.phase)
				PH_TYPE: begin
					case (data_byte)
						TYPE_SECTION_START: begin
							if (cur.list_open || cur.section_depth >= max_depth ||
							    {4'd0, cur.section_depth} >= NEST_LIMIT) begin
								err = 1'b1;
							end else begin
								kind      = KIND_SECTION_START;
								depth     = depth_inc;
								nxt.phase = PH_NLEN;
							end
						end
						TYPE_SECTION_END: begin
							if (cur.list_open || cur.section_depth == 4'd0) begin
								err = 1'b1;
							end else begin
								kind              = KIND_SECTION_END;
								done              = 1'b1;
								nxt.section_depth = cur.section_depth - 4'd1;
							end
						end
						TYPE_KEY_VALUE, TYPE_LIST_START: begin
							if (cur.list_open) begin
								err = 1'b1;
							end else begin
								kind      = data_byte[2:0];
								nxt.phase = PH_NLEN;
							end
						end
						TYPE_LIST_ITEM: begin
							if (!cur.list_open) begin
								err = 1'b1;
							end else begin
								kind      = KIND_LIST_ITEM;
								nxt.phase = PH_VHI;
							end
						end
						TYPE_LIST_END: begin
							if (!cur.list_open) begin
								err = 1'b1;
							end else begin
								kind          = KIND_LIST_END;
								done          = 1'b1;
								nxt.list_open = 1'b0;
							end
						end
						default: begin
							err = 1'b1;
						end
					endcase
					if (!err) begin
						nxt.current_kind = kind;
					end
				end
				PH_NLEN: begin
					kind = cur.current_kind;
					if (kind == KIND_SECTION_START) begin
						depth = depth_inc;
					end
					if (data_byte == 8'd0) begin
						err = 1'b1;
					end else begin
						nxt.bytes_left = {8'd0, data_byte};
						nxt.phase      = PH_NAME;
					end
				end
				PH_NAME: begin
					kind = cur.current_kind;
					if (kind == KIND_SECTION_START) begin
						depth = depth_inc;
					end
					nxt.bytes_left = count_dec;
					if (count_dec == 16'd0) begin
						// Name complete: a key-value goes on to its value length,
						// section and list starts are finished here.
						if (cur.current_kind == KIND_KEY_VALUE) begin
							nxt.phase = PH_VHI;
						end else begin
							if (cur.current_kind == KIND_SECTION_START) begin
								nxt.section_depth = depth_inc;
							end else begin
								nxt.list_open = 1'b1;
							end
							done      = 1'b1;
							nxt.phase = PH_TYPE;
						end
					end
				end
				PH_VHI: begin
					kind            = cur.current_kind;
					nxt.length_high = data_byte;
					nxt.phase       = PH_VLO;
				end
				PH_VLO: begin
					kind           = cur.current_kind;
					nxt.bytes_left = value_len;
					if (value_len == 16'd0) begin
						done      = 1'b1;
						nxt.phase = PH_TYPE;
					end else begin
						nxt.phase = PH_VAL;
					end
				end
				default: begin
					kind           = cur.current_kind;
					nxt.bytes_left = count_dec;
					if (count_dec == 16'd0) begin
						done      = 1'b1;
						nxt.phase = PH_TYPE;
					end
				end
			endcase
			// The first violation clears the element kind and done flag; an unfinished or
			// unbalanced message is flagged on its final byte.
			if (err) begin
				kind           = KIND_NONE;
				depth          = cur.section_depth;
				done           = 1'b0;
				nxt.error_seen = 1'b1;
			end else if (last_byte && (nxt.phase != PH_TYPE || nxt.list_open ||
			                           nxt.section_depth != 4'd0)) begin
				err = 1'b1;
			end
		end
		// The final byte returns the parser to its start state.
		if (last_byte) begin
			nxt = STATE_RESET;
		end
	end

	assign res = '{
		byte_out:       data_byte,
		byte_role:      role,
		element_kind:   kind,
		nest_depth:     depth,
		element_done:   done,
		message_done:   last_byte,
		protocol_error: err
	};

endmodule

// File: rtl/nested_tlv_message_parser.sv
// Top level of the nested TLV message parser: input register, parse step, result register.
// A result is presented from the result register once its byte has passed the input register and the parse step.
// Throughput: one byte per cycle while the output is not stalled; the single parse step between the input
// register and the result register updates the parser state whenever a byte advances.
// Reset: arst_n clears the parser state and both valid flags at once and sets
// the depth register to 8.
module nested_tlv_message_parser import nmp_pkg::*; #(
	parameter logic [7:0] NEST_LIMIT = DEPTH_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic [2:0] byte_role,
	output logic [2:0] element_kind,
	output logic [3:0] nest_depth,
	output logic       element_done,
	output logic       message_done,
	output logic       protocol_error
);

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          last_s1;
	logic [3:0]    max_depth_q;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res_nxt;
	parse_result_t res_s2;
	logic          valid_s2;
	logic          advance;

	// A byte moves from the input register to the result register whenever
	// the result register is empty or its transaction completes this cycle.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Depth limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= MAX_DEPTH_RESET;
		end else if (cfg_we) begin
			max_depth_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Parse step for the byte held in the input register.
	nmp_step #(
		.NEST_LIMIT (NEST_LIMIT)
	) u_step (
		.cur       (state_q),
		.max_depth (max_depth_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign byte_out       = res_s2.byte_out;
	assign byte_role      = res_s2.byte_role;
	assign element_kind   = res_s2.element_kind;
	assign nest_depth     = res_s2.nest_depth;
	assign element_done   = res_s2.element_done;
	assign message_done   = res_s2.message_done;
	assign protocol_error = res_s2.protocol_error;

`ifndef SYNTHESIS
	// A discarded byte carries no element information and no error.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && byte_role == ROLE_DISCARD) |->
		(!protocol_error && !element_done && element_kind == KIND_NONE &&
		 nest_depth == 4'd0))
	else $error("discarded byte carries element information");

	// The final byte of a message leaves the parser in its start state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=>
		(state_q.phase == PH_TYPE && state_q.section_depth == 4'd0 &&
		 !state_q.list_open && !state_q.error_seen))
	else $error("parser state not cleared after final byte");

	// A byte held in the input register is not overwritten while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)))
	else $error("waiting input byte lost");

	// A result marked as message end always reflects a byte taken with its end flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (valid_s2 && message_done == $past(last_s1)))
	else $error("message end flag mismatch");
`endif

endmodule

// File: sim/nested_tlv_message_parser_tb.sv
// Self-checking testbench for the nested TLV message parser, predicting the tag of every byte.
module nested_tlv_message_parser_tb;
	import nmp_pkg::*;

	// One message byte waiting to be sent.
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} msg_byte_t;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned LONG_HOLD   = 150;
	localparam int unsigned HOLD_AT     = 400;
	localparam int unsigned MAX_PRINTS  = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] byte_out;
	logic [2:0] byte_role;
	logic [2:0] element_kind;
	logic [3:0] nest_depth;
	logic       element_done;
	logic       message_done;
	logic       protocol_error;

	// Parser state as the block should hold it, and its copy of the depth register.
	parse_state_t  parser_state;
	logic [3:0]    depth_setting;

	msg_byte_t     pending_bytes[$];
	parse_result_t predicted_results[$];
	logic [7:0]    msg_bytes[$];

	msg_byte_t     next_byte;
	parse_result_t seen_result;
	parse_result_t want_result;
	int unsigned   queued_total = 0;
	int unsigned   results_seen = 0;
	int unsigned   mismatch_count = 0;
	int unsigned   send_gap = 0;
	int unsigned   stall_left = 0;
	int unsigned   hold_left = 0;
	int unsigned   quiet_cycles = 0;
	bit            idle_on = 1'b1;

	nested_tlv_message_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.byte_out      (byte_out),
		.byte_role     (byte_role),
		.element_kind  (element_kind),
		.nest_depth    (nest_depth),
		.element_done  (element_done),
		.message_done  (message_done),
		.protocol_error(protocol_error)
	);

	always #5 clk = ~clk;

	// Work out the tag of one byte and advance the parser state.
	function automatic parse_result_t predict_byte_result(input logic [7:0] b, input logic last);
		parse_result_t r;
		logic          err;
		r = '0;
		err = 1'b0;
		r.byte_out = b;
		r.message_done = last;
		if (parser_state.error_seen) begin
			r.byte_role = ROLE_DISCARD;
		end else begin
			r.byte_role = parser_state.phase;
			r.nest_depth = parser_state.section_depth;
			case (parser_state.phase)
				PH_TYPE: begin
					case (b)
						TYPE_SECTION_START: begin
							if (parser_state.list_open ||
									parser_state.section_depth >= depth_setting ||
									{4'd0, parser_state.section_depth} >= DEPTH_LIMIT) begin
								err = 1'b1;
							end else begin
								r.element_kind = KIND_SECTION_START;
								r.nest_depth = parser_state.section_depth + 4'd1;
								parser_state.phase = PH_NLEN;
							end
						end
						TYPE_SECTION_END: begin
							if (parser_state.list_open || parser_state.section_depth == 4'd0) begin
								err = 1'b1;
							end else begin
								r.element_kind = KIND_SECTION_END;
								r.element_done = 1'b1;
								parser_state.section_depth = parser_state.section_depth - 4'd1;
							end
						end
						TYPE_KEY_VALUE, TYPE_LIST_START: begin
							if (parser_state.list_open) begin
								err = 1'b1;
							end else begin
								r.element_kind = b[2:0];
								parser_state.phase = PH_NLEN;
							end
						end
						TYPE_LIST_ITEM: begin
							if (!parser_state.list_open) begin
								err = 1'b1;
							end else begin
								r.element_kind = KIND_LIST_ITEM;
								parser_state.phase = PH_VHI;
							end
						end
						TYPE_LIST_END: begin
							if (!parser_state.list_open) begin
								err = 1'b1;
							end else begin
								r.element_kind = KIND_LIST_END;
								r.element_done = 1'b1;
								parser_state.list_open = 1'b0;
							end
						end
						default: begin
							err = 1'b1;
						end
					endcase
					if (!err)
						parser_state.current_kind = r.element_kind;
				end
				PH_NLEN: begin
					r.element_kind = parser_state.current_kind;
					if (r.element_kind == KIND_SECTION_START)
						r.nest_depth = parser_state.section_depth + 4'd1;
					if (b == 8'd0) begin
						err = 1'b1;
					end else begin
						parser_state.bytes_left = {8'd0, b};
						parser_state.phase = PH_NAME;
					end
				end
				PH_NAME: begin
					r.element_kind = parser_state.current_kind;
					if (r.element_kind == KIND_SECTION_START)
						r.nest_depth = parser_state.section_depth + 4'd1;
					parser_state.bytes_left = parser_state.bytes_left - 16'd1;
					if (parser_state.bytes_left == 16'd0) begin
						// A key-value goes on to its value; the others end with the name.
						if (r.element_kind == KIND_KEY_VALUE) begin
							parser_state.phase = PH_VHI;
						end else begin
							if (r.element_kind == KIND_SECTION_START)
								parser_state.section_depth = parser_state.section_depth + 4'd1;
							else
								parser_state.list_open = 1'b1;
							r.element_done = 1'b1;
							parser_state.phase = PH_TYPE;
						end
					end
				end
				PH_VHI: begin
					r.element_kind = parser_state.current_kind;
					parser_state.length_high = b;
					parser_state.phase = PH_VLO;
				end
				PH_VLO: begin
					r.element_kind = parser_state.current_kind;
					parser_state.bytes_left = {parser_state.length_high, b};
					if (parser_state.bytes_left == 16'd0) begin
						r.element_done = 1'b1;
						parser_state.phase = PH_TYPE;
					end else begin
						parser_state.phase = PH_VAL;
					end
				end
				default: begin
					r.element_kind = parser_state.current_kind;
					parser_state.bytes_left = parser_state.bytes_left - 16'd1;
					if (parser_state.bytes_left == 16'd0) begin
						r.element_done = 1'b1;
						parser_state.phase = PH_TYPE;
					end
				end
			endcase
			// The first violation wins; otherwise the final byte checks the message is closed.
			if (err) begin
				r.element_kind = KIND_NONE;
				r.nest_depth = parser_state.section_depth;
				r.element_done = 1'b0;
				parser_state.error_seen = 1'b1;
			end else if (last && (parser_state.phase != PH_TYPE || parser_state.list_open ||
					parser_state.section_depth != 4'd0)) begin
				err = 1'b1;
			end
		end
		r.protocol_error = err;
		if (last)
			parser_state = STATE_RESET;
		return r;
	endfunction

	// Count a mismatch and print one line for it, for the first MAX_PRINTS mismatches only.
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("mismatch in %s at result %0d: got %0h, want %0h",
				what, results_seen, got, want);
	endtask

	// Move the message under construction into the send queue, marking its final byte.
	function automatic void commit_message();
		msg_byte_t item;
		foreach (msg_bytes[i]) begin
			item.value = msg_bytes[i];
			item.last = (i == msg_bytes.size() - 1);
			pending_bytes.push_back(item);
		end
		queued_total += msg_bytes.size();
		msg_bytes.delete();
	endfunction

	function automatic void append_name();
		int unsigned len;
		len = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4);
		msg_bytes.push_back(8'(len));
		repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Values are mostly short; now and then the high length byte is nonzero.
	function automatic void append_value();
		int unsigned len;
		len = ($urandom_range(0, 31) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 4);
		msg_bytes.push_back(8'(len >> 8));
		msg_bytes.push_back(8'(len));
		repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Build a mostly well-formed random message, closed in most cases.
	function automatic void build_message();
		int unsigned depth;
		int unsigned room;
		int unsigned pick;
		logic        in_list;
		depth = 0;
		in_list = 1'b0;
		room = (depth_setting < 4'd15) ? 32'(depth_setting) : 15;
		msg_bytes.delete();
		repeat ($urandom_range(1, 10)) begin
			if (in_list) begin
				if ($urandom_range(0, 3) == 0) begin
					msg_bytes.push_back(TYPE_LIST_END);
					in_list = 1'b0;
				end else begin
					msg_bytes.push_back(TYPE_LIST_ITEM);
					append_value();
				end
			end else begin
				pick = $urandom_range(0, 5);
				// Once in a while a section start goes past the allowed depth.
				if (pick <= 1 && (depth < room || $urandom_range(0, 15) == 0)) begin
					msg_bytes.push_back(TYPE_SECTION_START);
					append_name();
					depth++;
				end else if (pick == 2 && depth > 0) begin
					msg_bytes.push_back(TYPE_SECTION_END);
					depth--;
				end else if (pick == 3) begin
					msg_bytes.push_back(TYPE_LIST_START);
					append_name();
					in_list = 1'b1;
				end else begin
					msg_bytes.push_back(TYPE_KEY_VALUE);
					append_name();
					append_value();
				end
			end
		end
		if ($urandom_range(0, 15) != 0) begin
			if (in_list)
				msg_bytes.push_back(TYPE_LIST_END);
			repeat (depth) msg_bytes.push_back(TYPE_SECTION_END);
		end
	endfunction

	// Mostly well-formed messages; the rest are corrupted, cut short or pure noise.
	function automatic void add_random_message();
		int unsigned mode;
		int unsigned cut;
		mode = $urandom_range(0, 99);
		if (mode < 92) begin
			build_message();
			if (mode >= 76 && mode < 84) begin
				msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
			end else if (mode >= 84 && msg_bytes.size() > 1) begin
				cut = $urandom_range(1, msg_bytes.size() - 1);
				while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
			end
		end else begin
			msg_bytes.delete();
			repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
		end
		commit_message();
	endfunction

	// Wait until every byte is sent and every tag has come back, then let the pipeline settle.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || predicted_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_depth_limit(input logic [3:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		depth_setting = value;
	endtask

	task automatic run_phase(input int unsigned item_count, input bit with_idling);
		int unsigned start;
		idle_on = with_idling;
		start = queued_total;
		while (queued_total - start < item_count) add_random_message();
		wait_drained();
	endtask

	// Driver: presents queued bytes, predicting each tag as its transaction completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predicted_results.push_back(predict_byte_result(data_byte, last_byte));
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					next_byte = pending_bytes.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_byte.value;
					last_byte <= next_byte.last;
					if (idle_on && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transaction and drives the receiver's stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen_result = {byte_out, byte_role, element_kind, nest_depth,
					element_done, message_done, protocol_error};
				if (predicted_results.size() == 0) begin
					report_mismatch("unpredicted result", 32'(seen_result), 0);
				end else begin
					want_result = predicted_results.pop_front();
					if (seen_result.byte_out !== want_result.byte_out)
						report_mismatch("byte_out", 32'(seen_result.byte_out),
							32'(want_result.byte_out));
					if (seen_result.byte_role !== want_result.byte_role)
						report_mismatch("byte_role", 32'(seen_result.byte_role),
							32'(want_result.byte_role));
					if (seen_result.element_kind !== want_result.element_kind)
						report_mismatch("element_kind", 32'(seen_result.element_kind),
							32'(want_result.element_kind));
					if (seen_result.nest_depth !== want_result.nest_depth)
						report_mismatch("nest_depth", 32'(seen_result.nest_depth),
							32'(want_result.nest_depth));
					if (seen_result.element_done !== want_result.element_done)
						report_mismatch("element_done", 32'(seen_result.element_done),
							32'(want_result.element_done));
					if (seen_result.message_done !== want_result.message_done)
						report_mismatch("message_done", 32'(seen_result.message_done),
							32'(want_result.message_done));
					if (seen_result.protocol_error !== want_result.protocol_error)
						report_mismatch("protocol_error", 32'(seen_result.protocol_error),
							32'(want_result.protocol_error));
				end
				results_seen++;
				// One long hold-off so the block backs up and stalls its input.
				if (results_seen == HOLD_AT)
					hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if no transaction happens for too long while work is pending.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else if (pending_bytes.size() != 0 || in_valid || predicted_results.size() != 0) begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Stimulus: directed messages first, then random phases under several depth settings.
	// Each phase stops at a message boundary, so it runs somewhat past its byte count.
	initial begin
		parser_state = STATE_RESET;
		depth_setting = MAX_DEPTH_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// A balanced message with every element type, a zero-length value and a 0xFF byte.
		msg_bytes = '{TYPE_SECTION_START, 8'h01, 8'h41,
			TYPE_KEY_VALUE, 8'h01, 8'h6B, 8'h00, 8'h00,
			TYPE_LIST_START, 8'h01, 8'h4C,
			TYPE_LIST_ITEM, 8'h00, 8'h01, 8'hFF,
			TYPE_LIST_END, TYPE_SECTION_END};
		commit_message();
		// Unknown type 255, then a discarded final byte.
		msg_bytes = '{8'hFF, 8'h00};
		commit_message();
		// Zero name length on the final byte.
		msg_bytes = '{TYPE_KEY_VALUE, 8'h00};
		commit_message();
		// Message ends inside a section start.
		msg_bytes = '{TYPE_SECTION_START, 8'h01};
		commit_message();
		// Unknown types 0 and 7, each as a whole message.
		msg_bytes = '{8'h00};
		commit_message();
		msg_bytes = '{8'h07};
		commit_message();

		run_phase(100, 1'b1);
		write_depth_limit(4'd15);
		run_phase(125, 1'b1);
		write_depth_limit(4'd1);
		run_phase(125, 1'b1);
		write_depth_limit(4'd0);
		run_phase(100, 1'b1);
		write_depth_limit(4'($urandom_range(2, 14)));
		run_phase(125, 1'b1);
		write_depth_limit(MAX_DEPTH_RESET);
		run_phase(150, 1'b0);

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/nmp_pkg.sv
rtl/nmp_step.sv
rtl/nested_tlv_message_parser.sv
sim/nested_tlv_message_parser_tb.sv
